// ===== hw/rtl/modified_real_to_binary64_unit_assert.svh =====
// Assertion macros for the modified real to binary64 unit.
// Used by the pipeline modules; needs clk and arst_n in scope.
`ifndef MODIFIED_REAL_TO_BINARY64_UNIT_ASSERT_SVH
`define MODIFIED_REAL_TO_BINARY64_UNIT_ASSERT_SVH
// implication checked on every clock edge outside reset
`define MRB_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// implication checked in the cycle after the antecedent
`define MRB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== hw/rtl/mrb_pkg.sv =====
// Package for the modified real to binary64 unit: class codes and the
// stage records passed between pipeline modules. No dependencies.
package mrb_pkg;
	typedef enum logic [2:0] {
		CLS_ZERO   = 3'd0,
		CLS_DENORM = 3'd1,
		CLS_NORMAL = 3'd2,
		CLS_INF    = 3'd3,
		CLS_NAN    = 3'd4
	} cls_t;

	localparam logic [8:0]  EXP_ONES    = 9'd511;
	localparam logic [10:0] D_EXP_ONES  = 11'h7FF;
	localparam logic [10:0] NORM_BIAS   = 11'd768;
	localparam logic [10:0] DENORM_BIAS = 11'd747;

	// stage 1 record: decoded fields
	typedef struct packed {
		logic        neg;
		cls_t        cls;
		logic [8:0]  expo;
		logic [21:0] frac;
	} dec_t;

	// stage 2 record: leading-one position found
	typedef struct packed {
		logic        neg;
		cls_t        cls;
		logic [8:0]  expo;
		logic [21:0] frac;
		logic [4:0]  pos;
	} lzd_t;
endpackage

// ===== hw/rtl/mrb_decode.sv =====
// Stage 1: split the word and classify it.
// Depends on mrb_pkg.
module mrb_decode (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	input  logic [31:0]       raw_word,
	output logic              vld_s1,
	output mrb_pkg::dec_t     dec_s1
);
	logic [8:0]    expo;
	logic [21:0]   frac;
	mrb_pkg::cls_t cls;

	assign expo = raw_word[30:22];
	assign frac = raw_word[21:0];

	always_comb begin
		priority if (expo == 9'd0 && frac == 22'd0) cls = mrb_pkg::CLS_ZERO;
		else if (expo == mrb_pkg::EXP_ONES && frac == 22'd0) cls = mrb_pkg::CLS_INF;
		else if (expo == mrb_pkg::EXP_ONES) cls = mrb_pkg::CLS_NAN;
		else if (expo != 9'd0) cls = mrb_pkg::CLS_NORMAL;
		else cls = mrb_pkg::CLS_DENORM;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (in_vld) begin
			dec_s1 <= '{neg: raw_word[31], cls: cls, expo: expo, frac: frac};
		end
	end
endmodule

// ===== hw/rtl/mrb_lzd.sv =====
// Stage 2: leading-one search over the 22-bit fraction.
// Depends on mrb_pkg and the assertion header.
`include "modified_real_to_binary64_unit_assert.svh"
module mrb_lzd (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vld_s1,
	input  mrb_pkg::dec_t     dec_s1,
	output logic              vld_s2,
	output mrb_pkg::lzd_t     lzd_s2
);
	logic [4:0] pos;

	always_comb begin
		pos = 5'd0;
		for (int i = 0; i < 22; i++) begin
			if (dec_s1.frac[i]) pos = 5'(i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			lzd_s2 <= '{neg: dec_s1.neg, cls: dec_s1.cls, expo: dec_s1.expo,
				frac: dec_s1.frac, pos: pos};
		end
	end

	`MRB_ASSERT_IMPL(a_pos_set, vld_s2 && lzd_s2.cls == mrb_pkg::CLS_DENORM,
		lzd_s2.frac[lzd_s2.pos])
	`MRB_ASSERT_NEXT(a_vld_flow, vld_s1, vld_s2)
endmodule

// ===== hw/rtl/mrb_pack.sv =====
// Stage 3: shift the fraction and assemble the binary64 pattern.
// Depends on mrb_pkg and the assertion header.
`include "modified_real_to_binary64_unit_assert.svh"
module mrb_pack (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vld_s2,
	input  mrb_pkg::lzd_t     lzd_s2,
	output logic              vld_s3,
	output logic [2:0]        cls_s3,
	output logic              neg_s3,
	output logic [63:0]       bits_s3
);
	logic [10:0] dexp;
	logic [51:0] dfrac;
	logic [51:0] shifted;

	// drop the leading one by shifting it past the top of the fraction
	assign shifted = {30'd0, lzd_s2.frac} << (6'd52 - {1'b0, lzd_s2.pos});

	always_comb begin
		unique case (lzd_s2.cls)
			mrb_pkg::CLS_ZERO: begin
				dexp = 11'd0; dfrac = 52'd0;
			end
			mrb_pkg::CLS_INF: begin
				dexp = mrb_pkg::D_EXP_ONES; dfrac = 52'd0;
			end
			mrb_pkg::CLS_NAN: begin
				dexp = mrb_pkg::D_EXP_ONES;
				dfrac = {lzd_s2.frac, 30'd0} | {1'b1, 51'd0};
			end
			mrb_pkg::CLS_NORMAL: begin
				dexp = {2'b00, lzd_s2.expo} + mrb_pkg::NORM_BIAS;
				dfrac = {lzd_s2.frac, 30'd0};
			end
			default: begin
				dexp = {6'd0, lzd_s2.pos} + mrb_pkg::DENORM_BIAS;
				dfrac = shifted;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			cls_s3  <= lzd_s2.cls;
			neg_s3  <= lzd_s2.neg;
			bits_s3 <= {lzd_s2.neg, dexp, dfrac};
		end
	end

	`MRB_ASSERT_IMPL(a_sign_match, vld_s3, bits_s3[63] == neg_s3)
	`MRB_ASSERT_IMPL(a_exp_ones, vld_s3 && (cls_s3 == mrb_pkg::CLS_INF
		|| cls_s3 == mrb_pkg::CLS_NAN), bits_s3[62:52] == mrb_pkg::D_EXP_ONES)
endmodule

// ===== hw/rtl/modified_real_to_binary64_unit.sv =====
// Modified single real to IEEE-754 binary64 converter, top level.
// Depends on mrb_pkg, mrb_decode, mrb_lzd and mrb_pack.
//
// Usage:
//   Drive raw_word and pulse start; a word transfers at each rising edge
//   with start high and busy low. busy is always low: one word may enter
//   every cycle.
//   Each word yields one result on value_class, sign_negative and
//   double_bits, marked by done for exactly one cycle.
// Stages: decode, leading-one search and pack, in that order, one register
//   stage each; done is the valid bit registered at the pack stage.
// Throughput: one word per cycle, set by the three-stage pipeline.
// Reset: arst_n low clears all valid bits; no result appears until a word
//   is taken after reset. Payload registers are not reset.
// The receiver cannot stall: results appear once and must be taken.
// Conversion is exact; zero keeps its sign, NaN becomes a quiet NaN.
module modified_real_to_binary64_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] raw_word,
	output logic        done,
	output logic [2:0]  value_class,
	output logic        sign_negative,
	output logic [63:0] double_bits
);
	logic          vld_s1;
	logic          vld_s2;
	mrb_pkg::dec_t dec_s1;
	mrb_pkg::lzd_t lzd_s2;

	assign busy = 1'b0;

	mrb_decode u_decode (
		.clk(clk), .arst_n(arst_n), .in_vld(start && !busy), .raw_word(raw_word),
		.vld_s1(vld_s1), .dec_s1(dec_s1)
	);

	mrb_lzd u_lzd (
		.clk(clk), .arst_n(arst_n), .vld_s1(vld_s1), .dec_s1(dec_s1),
		.vld_s2(vld_s2), .lzd_s2(lzd_s2)
	);

	mrb_pack u_pack (
		.clk(clk), .arst_n(arst_n), .vld_s2(vld_s2), .lzd_s2(lzd_s2),
		.vld_s3(done), .cls_s3(value_class), .neg_s3(sign_negative),
		.bits_s3(double_bits)
	);
endmodule
